// ===== rtl/core/pidc_pkg.sv =====
// shared widths, register map, control types and saturation helper for the pid step
package pidc_pkg;

    // default fraction width of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // field and state widths
    localparam int DATA_W  = 32;
    localparam int DT_W    = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int STATE_W = 48;
    localparam int SUM_W   = STATE_W + 2;

    // shared multiplier: one 16-bit chunk of a 48-bit operand times a 33-bit operand
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = STATE_W / CHUNK_W;
    localparam int CHUNK_IW   = 2;
    localparam int MUL_A_W    = CHUNK_W + 1;
    localparam int MUL_B_W    = ERR_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = STATE_W + DATA_W;

    // divider quotient is widened to this before the saturation check
    localparam int DIV_X_W = 64;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;

    // operation codes of a request
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // saturation bounds of the 48-bit state
    localparam logic signed [STATE_W-1:0] SAT_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] SAT_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] limit_low;
        logic signed [DATA_W-1:0] limit_high;
    } cfg_t;

    // control of one multiply-accumulate step
    typedef struct packed {
        logic                issue;
        logic                clear;
        logic                last;
        logic [CHUNK_IW-1:0] chunk;
    } mac_ctl_t;

    // saturate a wide signed value to the signed 48-bit range
    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
        logic all_one;
        logic all_zero;
        all_one  = &x[ACC_W-1:STATE_W-1];
        all_zero = ~|x[ACC_W-1:STATE_W-1];
        if (all_one || all_zero)
            return x[STATE_W-1:0];
        else if (x[ACC_W-1])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

endpackage

// ===== rtl/core/pid_controller_step.sv =====
// PID step with clamped output: sequencer around a shared multiplier and a divider
//
// One update request runs error = target - measured, advances the integral
// and forms the derivative (only when time_step is nonzero), then sums
// gain_p*e + gain_i*I + gain_d*D and clamps it, limit_low being checked first.
// Each term is three 16-bit partial products through the one shared
// multiplier. With a nonzero time_step the derivative term waits for the
// bit-serial divider of 34 + FRAC_BITS steps, which runs beside the P and
// I terms; with a zero time_step the divider is not started. A clear
// request gives no result. The result sits in an output register, so the
// next request is taken while it waits; an update that finishes while the
// previous result is still held waits for it to leave.
// No clearing pass after reset.
module pid_controller_step #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
    input  logic [pidc_pkg::DATA_W-1:0]        pwdata,
    output logic [pidc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic signed [pidc_pkg::DATA_W-1:0] target,
    input  logic signed [pidc_pkg::DATA_W-1:0] measured,
    input  logic [pidc_pkg::DT_W-1:0]          time_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pidc_pkg::DATA_W-1:0] drive
);
    import pidc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_IWAIT  = 3'd2;
    localparam logic [2:0] S_IADD   = 3'd3;
    localparam logic [2:0] S_ISSUE  = 3'd4;
    localparam logic [2:0] S_TWAIT  = 3'd5;
    localparam logic [2:0] S_TADD   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    localparam logic [CHUNK_IW-1:0] CHUNK_TOP = CHUNK_IW'(NUM_CHUNKS - 1);

    cfg_t                       cfg;
    mac_ctl_t                   mac_ctl;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    mac_acc;
    logic                       mac_done;
    logic                       div_start;
    logic                       div_busy;
    logic signed [STATE_W-1:0]  div_q;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [1:0]                 term_reg;
    logic [1:0]                 term_next;
    logic [CHUNK_IW-1:0]        chunk_reg;
    logic [CHUNK_IW-1:0]        chunk_next;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff_next;
    logic [DT_W-1:0]            dt_reg;
    logic [DT_W-1:0]            dt_next;
    logic signed [STATE_W-1:0]  integ_reg;
    logic signed [STATE_W-1:0]  integ_next;
    logic signed [ERR_W-1:0]    last_err_reg;
    logic signed [ERR_W-1:0]    last_err_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [DATA_W-1:0]   drive_reg;
    logic signed [DATA_W-1:0]   drive_next;

    logic                       accept;
    logic                       dt_nz;
    logic signed [STATE_W-1:0]  term_op;
    logic signed [DATA_W-1:0]   term_gain;
    logic [CHUNK_W-1:0]         chunk_bits;
    logic                       chunk_sign;
    logic signed [SUM_W-1:0]    lim_lo;
    logic signed [SUM_W-1:0]    lim_hi;
    logic                       load_out;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    pidc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .diff     (diff_reg),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign dt_nz    = |dt_reg;

    // operand and gain of the current term
    always_comb
    begin
        case (term_reg)
            TERM_P:
            begin
                term_op   = STATE_W'(err_reg);
                term_gain = cfg.gain_p;
            end
            TERM_I:
            begin
                term_op   = integ_reg;
                term_gain = cfg.gain_i;
            end
            default:
            begin
                term_op   = dt_nz ? div_q : '0;
                term_gain = cfg.gain_d;
            end
        endcase
    end

    // chunk of the 48-bit operand, only the top chunk carries the sign
    assign chunk_bits = term_op[chunk_reg * CHUNK_W +: CHUNK_W];
    assign chunk_sign = (chunk_reg == CHUNK_TOP) ? term_op[STATE_W-1] : 1'b0;

    // clamp bounds
    assign lim_lo = SUM_W'($signed(cfg.limit_low));
    assign lim_hi = SUM_W'($signed(cfg.limit_high));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        chunk_next     = chunk_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        dt_next        = dt_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        load_out       = 1'b0;
        div_start      = 1'b0;
        mac_ctl        = '0;
        mul_a          = $signed({chunk_sign, chunk_bits});
        mul_b          = MUL_B_W'(term_gain);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_CLEAR)
                    begin
                        integ_next    = '0;
                        last_err_next = '0;
                    end
                    else
                    begin
                        err_next      = ERR_W'(target) - ERR_W'(measured);
                        diff_next     = DIFF_W'(err_next) - DIFF_W'(last_err_reg);
                        last_err_next = err_next;
                        dt_next       = time_step;
                        sum_next      = '0;
                        term_next     = TERM_P;
                        chunk_next    = '0;
                        state_next    = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH:
            begin
                if (dt_nz)
                begin
                    // integral step err * dt, divider runs alongside
                    div_start     = 1'b1;
                    mul_a         = $signed({1'b0, dt_reg});
                    mul_b         = err_reg;
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = 1'b1;
                    mac_ctl.last  = 1'b1;
                    state_next    = S_IWAIT;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_IWAIT:
            begin
                if (mac_done)
                    state_next = S_IADD;
            end
            S_IADD:
            begin
                integ_next = sat48(ACC_W'(integ_reg) + (mac_acc >>> FRAC_BITS));
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                // the derivative term waits for the divider
                if (!(term_reg == TERM_D && div_busy))
                begin
                    mac_ctl.issue = 1'b1;
                    mac_ctl.clear = chunk_reg == '0;
                    mac_ctl.last  = chunk_reg == CHUNK_TOP;
                    mac_ctl.chunk = chunk_reg;
                    if (chunk_reg == CHUNK_TOP)
                    begin
                        chunk_next = '0;
                        state_next = S_TWAIT;
                    end
                    else
                    begin
                        chunk_next = chunk_reg + 1'b1;
                    end
                end
            end
            S_TWAIT:
            begin
                if (mac_done)
                    state_next = S_TADD;
            end
            S_TADD:
            begin
                sum_next = sum_reg + SUM_W'(sat48(mac_acc >>> FRAC_BITS));
                if (term_reg == TERM_D)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    if (sum_reg < lim_lo)
                        drive_next = cfg.limit_low;
                    else if (sum_reg > lim_hi)
                        drive_next = cfg.limit_high;
                    else
                        drive_next = sum_reg[DATA_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    assign out_valid_next = load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= TERM_P;
            chunk_reg     <= '0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            chunk_reg     <= chunk_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        dt_reg    <= dt_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // divider is always finished by the time a new request can enter
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("divider still busy while idle");

    // the derivative term never reads a quotient that is still forming
    a_d_term: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_ctl.issue && state_reg == S_ISSUE && term_reg == TERM_D) |-> !div_busy)
        else $error("derivative term issued during division");

    // a clear request zeroes the controller state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_CLEAR) |=> (integ_reg == '0 && last_err_reg == '0))
        else $error("clear request did not reset state");

    // a result appears only from the final sequencer step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result without a finished update");

endmodule

// ===== rtl/core/pidc_regs.sv =====
// apb register file holding the gains and output limits
module pidc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
    output logic [pidc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pidc_pkg::cfg_t                cfg
);
    import pidc_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_P:     cfg_next.gain_p     = pwdata;
                REG_GAIN_I:     cfg_next.gain_i     = pwdata;
                REG_GAIN_D:     cfg_next.gain_d     = pwdata;
                REG_LIMIT_LOW:  cfg_next.limit_low  = pwdata;
                REG_LIMIT_HIGH: cfg_next.limit_high = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // read decode
    always_comb
    begin
        unique case (idx)
            REG_GAIN_P:     prdata = cfg_reg.gain_p;
            REG_GAIN_I:     prdata = cfg_reg.gain_i;
            REG_GAIN_D:     prdata = cfg_reg.gain_d;
            REG_LIMIT_LOW:  prdata = cfg_reg.limit_low;
            REG_LIMIT_HIGH: prdata = cfg_reg.limit_high;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= '0;
            cfg_reg.gain_i     <= '0;
            cfg_reg.gain_d     <= '0;
            cfg_reg.limit_low  <= {1'b1, {(DATA_W-1){1'b0}}};
            cfg_reg.limit_high <= {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/pidc_mac.sv =====
// shared multiply-accumulate unit: chunk times operand, shifted into a wide accumulator
module pidc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pidc_pkg::mac_ctl_t                  ctl,
    input  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a,
    input  logic signed [pidc_pkg::MUL_B_W-1:0] mul_b,
    output logic signed [pidc_pkg::ACC_W-1:0]   acc,
    output logic                                done
);
    import pidc_pkg::*;

    mac_ctl_t                  ctl_d_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   addend;
    logic                      done_reg;

    // product stage
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // accumulate stage, the chunk picks the weight of the partial product
    assign addend = ACC_W'(prod_reg) <<< (ctl_d_reg.chunk * CHUNK_W);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_d_reg.issue)
        begin
            if (ctl_d_reg.clear)
                acc_next = addend;
            else
                acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_d_reg <= ctl;
            done_reg  <= ctl_d_reg.issue && ctl_d_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/pidc_div.sv =====
// restoring divider for the derivative: (diff << FRAC_BITS) / dt, one quotient bit a cycle
module pidc_div #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pidc_pkg::DIFF_W-1:0]  diff,
    input  logic [pidc_pkg::DT_W-1:0]           divisor,
    output logic                                busy,
    output logic signed [pidc_pkg::STATE_W-1:0] quotient
);
    import pidc_pkg::*;

    localparam int DW    = DIFF_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]              quo_reg;
    logic [DW-1:0]              quo_next;
    logic [DT_W-1:0]            rem_reg;
    logic [DT_W-1:0]            rem_next;
    logic [DT_W-1:0]            dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       neg_reg;
    logic signed [STATE_W-1:0]  res_reg;
    logic signed [STATE_W-1:0]  res_next;
    logic [DIFF_W-1:0]          mag;
    logic [DT_W:0]              trial;
    logic [DT_W:0]              trial_sub;
    logic                       fits;
    logic                       last_step;
    logic [DIV_X_W-1:0]         qx;
    logic                       ovf;

    // magnitude of the signed difference
    assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // one restoring step
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign last_step = cnt_reg == CNT_W'(DW - 1);

    // sign and saturation on the final quotient
    assign qx  = DIV_X_W'(quo_next);
    assign ovf = |qx[DIV_X_W-1:STATE_W-1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        res_next  = res_reg;
        if (start && !busy_reg)
        begin
            quo_next  = {mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                cnt_next  = '0;
                if (neg_reg)
                    res_next = ovf ? SAT_MIN : -$signed(qx[STATE_W-1:0]);
                else
                    res_next = ovf ? SAT_MAX : $signed(qx[STATE_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (start && !busy_reg)
        begin
            dvs_reg <= divisor;
            neg_reg <= diff[DIFF_W-1];
        end
    end

    assign busy     = busy_reg;
    assign quotient = res_reg;

    // a start while idle always begins a division
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

endmodule
